>>> rtl/core/grunwald_letnikov_fractional_derivative_unit_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef GRUNWALD_LETNIKOV_FRACTIONAL_DERIVATIVE_UNIT_ASSERT_SVH
`define GRUNWALD_LETNIKOV_FRACTIONAL_DERIVATIVE_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is high.
`define GLFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked through reset as well.
`define GLFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/glfd_pkg.sv
package glfd_pkg;

  // Field and register widths
  localparam int ALPHA_W    = 15;
  localparam int SCALE_W    = 32;
  localparam int COEF_W     = 32;
  localparam int ALPHA_FRAC = 12;
  localparam int RESULT_W   = 32;
  localparam int ACC_W      = 64;

  // Configuration register indexes
  localparam logic [0:0] CFG_ALPHA = 1'b0;
  localparam logic [0:0] CFG_SCALE = 1'b1;

  // Reset values and fixed constants
  localparam logic signed [ALPHA_W-1:0] ALPHA_RESET = 15'sd2048;
  localparam logic [SCALE_W-1:0]        SCALE_RESET = 32'd65536;
  localparam logic signed [COEF_W-1:0]  COEF_ONE    = 32'sh4000_0000;

  // Status flags that go with each result item
  typedef struct packed {
    logic truncated;
    logic saturated;
  } res_flags_t;

endpackage

>>> rtl/core/grunwald_letnikov_fractional_derivative_unit.sv
// Grunwald-Letnikov fractional derivative: each sample item yields one result,
// step_scale times the sum of b_j times the sample j places back, over up to
// MAX_POINTS stored samples of the current sequence. One history read and one
// coefficient read per cycle feed the terms of an item into
// a single multiply-accumulate. The coefficients depend on alpha only and are
// kept in a coefficient memory; the first time term j is needed after reset or
// after order_alpha is written, it is built by a bit-serial divider, so a long
// first sequence is slower. There is no clearing pass after reset. A two-entry
// queue lets samples be taken while the arithmetic runs, and an output register
// holds a result until it is taken.
module grunwald_letnikov_fractional_derivative_unit
  import glfd_pkg::*;
#(
  parameter int MAX_POINTS  = 1024,
  parameter int SAMPLE_BITS = 16,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int AW    = $clog2(MAX_POINTS),
  localparam int CW    = $clog2(MAX_POINTS + 1),
  localparam int JOB_W = SAMPLE_BITS + AW + CW + 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_W-1:0]     s_tdata,   // [SAMPLE_BITS-1:0] sample
  input  logic                s_tuser,   // [0] start_req
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [RESULT_W-1:0] m_tdata,   // [31:0] derivative
  output logic [1:0]          m_tuser,   // [0] saturated, [1] truncated
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  logic signed [ALPHA_W-1:0] order_alpha;
  logic [SCALE_W-1:0]        step_scale;
  logic                      alpha_wr;
  logic                      fq_valid;
  logic                      fq_ready;
  logic [JOB_W-1:0]          fq_data;
  logic                      qb_valid;
  logic                      qb_ready;
  logic [JOB_W-1:0]          qb_data;
  res_flags_t                flags;

  // Configuration registers
  assign alpha_wr = cfg_we && (cfg_index == CFG_ALPHA);
  always_ff @(posedge clk) begin
    if (rst) begin
      order_alpha <= ALPHA_RESET;
      step_scale  <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ALPHA: order_alpha <= $signed(cfg_data[ALPHA_W-1:0]);
        CFG_SCALE: step_scale  <= cfg_data[SCALE_W-1:0];
        default:   ;
      endcase
    end
  end

  glfd_front #(.MAX_POINTS(MAX_POINTS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_sample (s_tdata[SAMPLE_BITS-1:0]),
    .in_start  (s_tuser),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_data    (fq_data)
  );

  glfd_queue #(.WIDTH(JOB_W)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fq_valid),
    .in_ready  (fq_ready),
    .in_data   (fq_data),
    .out_valid (qb_valid),
    .out_ready (qb_ready),
    .out_data  (qb_data)
  );

  glfd_back #(.MAX_POINTS(MAX_POINTS), .SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .alpha     (order_alpha),
    .scale     (step_scale),
    .alpha_wr  (alpha_wr),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job_data  (qb_data),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res_value (m_tdata),
    .res_flags (flags)
  );

  assign m_tuser = {flags.truncated, flags.saturated};

endmodule

>>> rtl/core/glfd_ram.sv
module glfd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> rtl/core/glfd_queue.sv
module glfd_queue #(
  parameter int WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] slots [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slots[rptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= in_data;
    end
  end

endmodule

>>> rtl/core/glfd_front.sv
module glfd_front #(
  parameter int MAX_POINTS  = 1024,
  parameter int SAMPLE_BITS = 16,
  localparam int AW    = $clog2(MAX_POINTS),
  localparam int CW    = $clog2(MAX_POINTS + 1),
  localparam int JOB_W = SAMPLE_BITS + AW + CW + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_start,
  output logic                   q_valid,
  input  logic                   q_ready,
  output logic [JOB_W-1:0]       q_data
);

  logic [CW-1:0] sample_index;
  logic [AW-1:0] ring_head;
  logic [CW-1:0] idx_eff;
  logic [AW-1:0] slot;
  logic          trunc;
  logic [CW-1:0] n_terms;
  logic          accept;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign accept   = in_valid && q_ready;

  // A start item restarts the sequence at slot zero
  assign idx_eff = in_start ? '0 : sample_index;
  assign slot    = in_start ? '0 : ring_head;
  assign trunc   = (idx_eff == CW'(MAX_POINTS));
  assign n_terms = trunc ? idx_eff : idx_eff + 1'b1;

  // Job word: sample, ring slot, term count, truncation flag
  assign q_data = {trunc, n_terms, slot, in_sample};

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index <= '0;
      ring_head    <= '0;
    end else if (accept) begin
      sample_index <= n_terms;
      ring_head    <= (slot == AW'(MAX_POINTS - 1)) ? '0 : slot + 1'b1;
    end
  end

endmodule

>>> rtl/core/glfd_back.sv
module glfd_back
  import glfd_pkg::*;
#(
  parameter int MAX_POINTS  = 1024,
  parameter int SAMPLE_BITS = 16,
  localparam int AW    = $clog2(MAX_POINTS),
  localparam int CW    = $clog2(MAX_POINTS + 1),
  localparam int JOB_W = SAMPLE_BITS + AW + CW + 1
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic signed [ALPHA_W-1:0] alpha,
  input  logic [SCALE_W-1:0]        scale,
  input  logic                      alpha_wr,
  input  logic                      job_valid,
  output logic                      job_ready,
  input  logic [JOB_W-1:0]          job_data,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic [RESULT_W-1:0]       res_value,
  output res_flags_t                res_flags
);

  localparam int NW  = AW + 14;                  // recurrence numerator
  localparam int PW  = COEF_W + NW;              // coefficient times numerator
  localparam int DW  = PW - ALPHA_FRAC;          // dividend after the 2^12 of the divisor
  localparam int DCW = $clog2(DW + 1);
  localparam int MW  = COEF_W + SAMPLE_BITS;     // tap product
  localparam int QW  = ACC_W - 14;               // rounded scaled magnitude

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_CMUL, S_CABS, S_CDIV, S_CSTORE,
    S_ACC, S_DRAIN, S_SLO, S_SHI, S_ROUND, S_DONE
  } state_t;

  state_t state;

  // Job fields
  logic [SAMPLE_BITS-1:0] job_sample;
  logic [AW-1:0]          job_slot;
  logic [CW-1:0]          job_n;
  logic                   job_trunc;
  logic                   pop;

  assign {job_trunc, job_n, job_slot, job_sample} = job_data;
  assign job_ready = (state == S_IDLE);
  assign pop       = job_valid && job_ready;

  // Per-item registers
  logic [CW-1:0]             n_cur;
  logic                      trunc_cur;
  logic [AW-1:0]             pos;
  logic [CW-1:0]             jidx;

  // Coefficient builder
  logic [CW-1:0]             coef_count;
  logic signed [COEF_W-1:0]  c_last;
  logic signed [PW-1:0]      cprod;
  logic                      cneg;
  logic [DW-1:0]             dquo;
  logic [AW-1:0]             drem;
  logic [DCW-1:0]            dcnt;
  logic [AW-1:0]             jnew;
  logic [AW-1:0]             jm1;
  logic signed [NW-1:0]      num;
  logic [PW-1:0]             pmag;
  logic [AW:0]               trial;
  logic                      ge;
  logic [AW:0]               trial_sub;
  logic                      big_pos;
  logic                      big_neg;
  logic [COEF_W-1:0]         cval;

  // Multiply-accumulate pipe
  logic                      v1;
  logic                      v2;
  logic signed [MW-1:0]      mprod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   tap;
  logic signed [ACC_W:0]     sum;
  logic signed [ACC_W-1:0]   acc_add;
  logic [ACC_W-1:0]          mag;
  logic [ACC_W-1:0]          lo;
  logic [ACC_W-1:0]          hi;
  logic [ACC_W-1:0]          tsum;
  logic [QW-1:0]             qv;

  // Memory ports
  logic                      ring_we;
  logic [SAMPLE_BITS-1:0]    ring_rd;
  logic                      coef_we;
  logic [AW-1:0]             coef_waddr;
  logic [COEF_W-1:0]         coef_wdata;
  logic [COEF_W-1:0]         coef_rd;

  // Final rounding and clipping
  logic                      out_load;
  logic                      q_big_pos;
  logic                      q_big_neg;
  logic [RESULT_W-1:0]       res_calc;
  logic                      sat_calc;

  glfd_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_POINTS)) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (job_slot),
    .wr_data (job_sample),
    .rd_addr (pos),
    .rd_data (ring_rd)
  );

  glfd_ram #(.WIDTH(COEF_W), .DEPTH(MAX_POINTS)) u_coef (
    .clk     (clk),
    .wr_en   (coef_we),
    .wr_addr (coef_waddr),
    .wr_data (coef_wdata),
    .rd_addr (jidx[AW-1:0]),
    .rd_data (coef_rd)
  );

  assign ring_we = pop;

  // Recurrence step: b_j = b_(j-1) * ((j-1)*4096 - alpha) / (j*4096)
  assign jnew  = coef_count[AW-1:0];
  assign jm1   = jnew - 1'b1;
  assign num   = $signed({2'b00, jm1, 12'b0}) - NW'(alpha);
  assign pmag  = cprod[PW-1] ? PW'(-cprod) : PW'(cprod);
  assign trial = {drem, dquo[DW-1]};
  assign ge    = (trial >= {1'b0, jnew});
  assign trial_sub = trial - {1'b0, jnew};

  // Clip the quotient to Q2.30 range
  assign big_pos = (dquo > DW'(64'h7fff_ffff));
  assign big_neg = (dquo > DW'(64'h8000_0000));
  always_comb begin
    if (cneg) begin
      cval = big_neg ? 32'h8000_0000 : 32'(-dquo[COEF_W-1:0]);
    end else begin
      cval = big_pos ? 32'h7fff_ffff : dquo[COEF_W-1:0];
    end
  end

  // Coefficient store writes: b_0 on first fill, later terms from the divider
  always_comb begin
    coef_we    = 1'b0;
    coef_waddr = jnew;
    coef_wdata = cval;
    if (state == S_FILL && coef_count == '0) begin
      coef_we    = 1'b1;
      coef_waddr = '0;
      coef_wdata = COEF_ONE;
    end else if (state == S_CSTORE) begin
      coef_we = 1'b1;
    end
  end

  // Saturating 64-bit accumulate
  assign tap = ACC_W'(mprod);
  assign sum = {acc[ACC_W-1], acc} + {tap[ACC_W-1], tap};
  always_comb begin
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      acc_add = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_add = sum[ACC_W-1:0];
    end
  end

  assign mag  = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign tsum = hi + {32'b0, lo[ACC_W-1:32]};

  // Round-to-nearest result clipped to 32 bits
  assign q_big_pos = (qv > QW'(64'h7fff_ffff));
  assign q_big_neg = (qv > QW'(64'h8000_0000));
  always_comb begin
    if (acc[ACC_W-1]) begin
      sat_calc = q_big_neg;
      res_calc = q_big_neg ? 32'h8000_0000 : 32'(-qv[RESULT_W-1:0]);
    end else begin
      sat_calc = q_big_pos;
      res_calc = q_big_pos ? 32'h7fff_ffff : qv[RESULT_W-1:0];
    end
  end

  assign out_load = (state == S_DONE) && (!res_valid || res_ready);

  // Fill count of the coefficient store; a new alpha invalidates every entry
  always_ff @(posedge clk) begin
    if (rst || alpha_wr) begin
      coef_count <= '0;
    end else if (state == S_FILL && coef_count == '0) begin
      coef_count <= CW'(1);
    end else if (state == S_CSTORE) begin
      coef_count <= coef_count + 1'b1;
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      res_valid  <= 1'b0;
      dcnt       <= '0;
    end else begin
      if (res_valid && res_ready && !out_load) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) state <= S_FILL;
        end
        S_FILL: begin
          if (coef_count >= n_cur) begin
            state <= S_ACC;
          end else if (coef_count != '0) begin
            state <= S_CMUL;
          end
        end
        S_CMUL: state <= S_CABS;
        S_CABS: begin
          dcnt  <= DCW'(DW);
          state <= S_CDIV;
        end
        S_CDIV: begin
          dcnt <= dcnt - 1'b1;
          if (dcnt == DCW'(1)) state <= S_CSTORE;
        end
        S_CSTORE: begin
          state <= S_FILL;
        end
        S_ACC: begin
          if (jidx == n_cur - 1'b1) state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!v1 && !v2) state <= S_SLO;
        end
        S_SLO:   state <= S_SHI;
        S_SHI:   state <= S_ROUND;
        S_ROUND: state <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            res_valid           <= 1'b1;
            res_value           <= res_calc;
            res_flags.saturated <= sat_calc;
            res_flags.truncated <= trunc_cur;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Pipe valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == S_ACC);
      v2 <= v1;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      n_cur     <= job_n;
      trunc_cur <= job_trunc;
      pos       <= job_slot;
      jidx      <= '0;
      acc       <= '0;
    end
    if (state == S_FILL && coef_count == '0) c_last <= COEF_ONE;
    if (state == S_CMUL) cprod <= PW'(c_last) * PW'(num);
    if (state == S_CABS) begin
      cneg <= cprod[PW-1];
      dquo <= pmag[PW-1:ALPHA_FRAC];
      drem <= '0;
    end
    if (state == S_CDIV) begin
      drem <= ge ? trial_sub[AW-1:0] : trial[AW-1:0];
      dquo <= {dquo[DW-2:0], ge};
    end
    if (state == S_CSTORE) c_last <= $signed(cval);
    // Walk the ring newest first while the coefficient index counts up
    if (state == S_ACC) begin
      jidx <= jidx + 1'b1;
      pos  <= (pos == '0) ? AW'(MAX_POINTS - 1) : pos - 1'b1;
    end
    if (v1) mprod <= MW'($signed(coef_rd)) * MW'($signed(ring_rd));
    if (v2) acc <= acc_add;
    // 64 x 32 scale as two 32 x 32 products
    if (state == S_SLO) lo <= ACC_W'(mag[31:0]) * ACC_W'(scale);
    if (state == S_SHI) hi <= ACC_W'(mag[ACC_W-1:32]) * ACC_W'(scale);
    if (state == S_ROUND) qv <= QW'((tsum + 64'd8192) >> 14);
  end

endmodule

>>> rtl/core/glfd_checker.sv
`include "grunwald_letnikov_fractional_derivative_unit_assert.svh"

module glfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // A stalled result stays put
  `GLFD_ASSERT_NEXT(a_hold, !rst && m_tvalid && !m_tready, rst || (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "result changed while stalled")

  // Saturated results sit exactly at a 32-bit bound
  `GLFD_ASSERT_IMP(a_sat_bound, m_tvalid && m_tuser[0], m_tdata == 32'h7fff_ffff || m_tdata == 32'h8000_0000, "saturated flag without clipped value")

  // Reset empties the output register and the queue
  `GLFD_ASSERT_NEXT(a_rst_out, rst, !m_tvalid, "result valid right after reset")
  `GLFD_ASSERT_NEXT(a_rst_in, rst, s_tready, "input not ready right after reset")

endmodule

bind grunwald_letnikov_fractional_derivative_unit glfd_checker u_glfd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
